// File: hdl/ambs_pkg.sv
`timescale 1ns / 1ps

package ambs_pkg;

    // store depth default, and the reset frame length
    localparam int MAX_PIXELS_DEFAULT = 16384;
    localparam int FRAME_PIXELS_RESET = 16384;

    localparam int PIX_W      = 8;
    localparam int FRAME_W    = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'd1;

    // input word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // frame status codes
    localparam logic STATUS_LEARNING  = 1'b0;
    localparam logic STATUS_DETECTION = 1'b1;

    localparam logic [PIX_W-1:0] THRESH_DIGIT = 8'd150;
    localparam logic [PIX_W-1:0] THRESH_WAVE  = 8'd90;
    localparam logic [PIX_W-1:0] FG_VALUE     = 8'd255;
    localparam logic [PIX_W-1:0] BG_VALUE     = 8'd0;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_status;
        logic             last_of_frame;
    } out_word_t;

    // per-pixel control carried from the sequencer down the pipeline
    typedef struct packed {
        logic learned;
        logic last;
    } step_flags_t;

endpackage

// File: hdl/ambs_ram.sv
`timescale 1ns / 1ps

module ambs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ambs_sequencer.sv
`timescale 1ns / 1ps

module ambs_sequencer #(
    parameter int MAX_PIXELS = ambs_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ambs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ambs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               step,
    input  logic                               clear,
    output logic [$clog2(MAX_PIXELS)-1:0]      idx,
    output ambs_pkg::step_flags_t              flags
);

    localparam int ADDR_W  = $clog2(MAX_PIXELS);
    localparam int LEN_W   = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W   = ((LEN_W > ambs_pkg::FRAME_W) ? LEN_W : ambs_pkg::FRAME_W) + 1;
    localparam int RESET_LEN = (ambs_pkg::FRAME_PIXELS_RESET < MAX_PIXELS)
                               ? ambs_pkg::FRAME_PIXELS_RESET : MAX_PIXELS;
    localparam logic [ADDR_W-1:0] RESET_LAST = ADDR_W'(RESET_LEN - 1);
    localparam logic [CMP_W-1:0]  MAX_LEN    = CMP_W'(MAX_PIXELS);

    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0] pixel_index_reg, pixel_index_next;
    logic              learned_reg, learned_next;
    logic [CMP_W-1:0]  len_req;
    logic [CMP_W-1:0]  len_eff;
    logic              is_last;

    // clamp the requested frame length into 1..MAX_PIXELS, kept as last index
    always_comb
    begin
        len_req = CMP_W'(cfg_data[ambs_pkg::FRAME_W-1:0]);
        len_eff = len_req;
        if (len_req == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_req > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        last_idx_next = last_idx_reg;
        if (cfg_we && (cfg_index == ambs_pkg::REG_FRAME_PIXELS))
        begin
            last_idx_next = ADDR_W'(len_eff - CMP_W'(1));
        end
    end

    // a position beyond a shortened frame restarts at zero
    always_comb
    begin
        idx = (pixel_index_reg > last_idx_reg) ? '0 : pixel_index_reg;
        is_last = (idx == last_idx_reg);
        pixel_index_next = pixel_index_reg;
        learned_next = learned_reg;
        if (clear)
        begin
            pixel_index_next = '0;
            learned_next = 1'b0;
        end
        else if (step)
        begin
            pixel_index_next = is_last ? '0 : idx + ADDR_W'(1);
            if (is_last)
            begin
                learned_next = 1'b1;
            end
        end
    end

    assign flags.learned = learned_reg;
    assign flags.last    = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg    <= RESET_LAST;
            pixel_index_reg <= '0;
            learned_reg     <= 1'b0;
        end
        else
        begin
            last_idx_reg    <= last_idx_next;
            pixel_index_reg <= pixel_index_next;
            learned_reg     <= learned_next;
        end
    end

endmodule

// File: hdl/ambs_pixel_unit.sv
`timescale 1ns / 1ps

module ambs_pixel_unit (
    input  logic [ambs_pkg::PIX_W-1:0] pix,
    input  logic [ambs_pkg::PIX_W-1:0] bg,
    input  ambs_pkg::step_flags_t      flags,
    input  logic                       wave_mode,
    output logic [ambs_pkg::PIX_W-1:0] bg_new,
    output ambs_pkg::out_word_t        result
);

    logic [ambs_pkg::PIX_W-1:0] stepped;
    logic [ambs_pkg::PIX_W-1:0] diff;
    logic [ambs_pkg::PIX_W-1:0] thr;

    // step the background one count toward the pixel once learned; while learning it takes the pixel
    always_comb
    begin
        if (pix > bg)
        begin
            stepped = bg + 8'd1;
        end
        else if (pix < bg)
        begin
            stepped = bg - 8'd1;
        end
        else
        begin
            stepped = bg;
        end
        diff = (pix > stepped) ? (pix - stepped) : (stepped - pix);
        thr  = wave_mode ? ambs_pkg::THRESH_WAVE : ambs_pkg::THRESH_DIGIT;

        result.last_of_frame = flags.last;
        if (flags.learned)
        begin
            bg_new = stepped;
            result.pixel_out = (diff > thr) ? ambs_pkg::FG_VALUE : ambs_pkg::BG_VALUE;
            result.frame_status = ambs_pkg::STATUS_DETECTION;
        end
        else
        begin
            bg_new = pix;
            result.pixel_out = pix;
            result.frame_status = ambs_pkg::STATUS_LEARNING;
        end
    end

endmodule

// File: hdl/approx_median_background_subtract.sv
`timescale 1ns / 1ps
// an accepted pixel word is held in the stage-1 registers while the background ram is read, and
// is then loaded into the output register once that register is free
// throughput: one pixel word per cycle unless out_stall holds the output; the background ram reads one
// entry and writes one back each cycle, with the previous write forwarded when it hits the same entry
// clear words produce no output
// reset clears frame position and learned flag and restores config defaults; the background ram is not cleared

module approx_median_background_subtract #(
    parameter int MAX_PIXELS = ambs_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ambs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ambs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ambs_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ambs_pkg::out_word_t             out_data
);

    localparam int ADDR_W = $clog2(MAX_PIXELS);

    logic                        in_accept;
    logic                        pix_accept;
    logic                        clr_accept;
    logic [ADDR_W-1:0]           rd_idx;
    ambs_pkg::step_flags_t       seq_flags;
    logic [ambs_pkg::PIX_W-1:0]  rd_data;
    logic [ambs_pkg::PIX_W-1:0]  bg_cur;
    logic [ambs_pkg::PIX_W-1:0]  bg_new;
    ambs_pkg::out_word_t         result;
    logic                        out_free;
    logic                        s1_adv;

    logic                        wave_mode_reg, wave_mode_next;
    logic                        s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic [ambs_pkg::PIX_W-1:0]  s1_pix_reg;
    ambs_pkg::step_flags_t       s1_flags_reg;
    logic                        fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]           fwd_addr_reg;
    logic [ambs_pkg::PIX_W-1:0]  fwd_data_reg;
    logic                        out_valid_reg, out_valid_next;
    ambs_pkg::out_word_t         out_data_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_adv     = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;
    assign pix_accept = in_accept && (in_data.kind == ambs_pkg::KIND_PIXEL);
    assign clr_accept = in_accept && (in_data.kind == ambs_pkg::KIND_CLEAR);

    ambs_sequencer #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (pix_accept),
        .clear     (clr_accept),
        .idx       (rd_idx),
        .flags     (seq_flags)
    );

    ambs_ram #(
        .WIDTH (ambs_pkg::PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_bg_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (bg_new),
        .re    (pix_accept),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    // the latest write wins over a stale ram read of the same entry
    assign bg_cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    ambs_pixel_unit u_pix (
        .pix       (s1_pix_reg),
        .bg        (bg_cur),
        .flags     (s1_flags_reg),
        .wave_mode (wave_mode_reg),
        .bg_new    (bg_new),
        .result    (result)
    );

    always_comb
    begin
        wave_mode_next = wave_mode_reg;
        if (cfg_we && (cfg_index == ambs_pkg::REG_WAVE_MODE))
        begin
            wave_mode_next = cfg_data[0];
        end
        s1_valid_next  = pix_accept || (s1_valid_reg && !s1_adv);
        fwd_valid_next = fwd_valid_reg || s1_adv;
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wave_mode_reg <= wave_mode_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_addr_reg  <= rd_idx;
            s1_pix_reg   <= in_data.pixel_value;
            s1_flags_reg <= seq_flags;
        end
        if (s1_adv)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= bg_new;
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
